/* hdl/levenshtein_automaton_matcher_unit_macros.svh */
// Assertion helpers shared by the matcher RTL.
`ifndef LEVENSHTEIN_AUTOMATON_MATCHER_UNIT_MACROS_SVH
`define LEVENSHTEIN_AUTOMATON_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lam_pkg.sv */
package lam_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int EDITS_MAX   = 3;
  localparam int CELLS       = PATTERN_MAX + 1;
  localparam int ROWS        = EDITS_MAX + 1;

  localparam int SYMBOL_W    = 8;
  localparam int LENGTH_W    = 5;
  localparam int EDITS_W     = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_EDITS      = CFG_INDEX_W'(3);

  // Broadcast to every cell for the item in flight.
  typedef struct packed {
    logic                step;
    logic                word_open;
    logic                is_symbol;
    logic [SYMBOL_W-1:0] symbol;
    logic [ROWS-1:0]     row_mask;
  } lam_ctrl_t;

  // Where a cell sits relative to the active pattern length.
  typedef struct packed {
    logic first;
    logic below;
    logic at;
  } lam_pos_t;

  // Handed from a cell to its right neighbor.
  typedef struct packed {
    logic [ROWS-1:0] col1;
    logic [ROWS-1:0] col2;
    logic            hit;
    logic            below;
  } lam_link_t;

endpackage

/* hdl/lam_cell.sv */
module lam_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lam_pkg::lam_ctrl_t            ctrl,
  input  lam_pkg::lam_pos_t             pos,
  input  logic [lam_pkg::SYMBOL_W-1:0]  pat_byte,
  input  lam_pkg::lam_link_t            left,
  output lam_pkg::lam_link_t            right,
  output logic                          tap
);

  logic [lam_pkg::ROWS-1:0] col_r;
  logic [lam_pkg::ROWS-1:0] col_nxt;
  logic [lam_pkg::ROWS-1:0] seed;
  logic [lam_pkg::ROWS-1:0] c1;
  logic [lam_pkg::ROWS-1:0] v;
  logic [lam_pkg::ROWS-1:0] c2;
  logic                     in_range;
  logic                     hit;

  assign in_range = pos.below | pos.at;
  assign hit      = pos.below & (pat_byte == ctrl.symbol);
  assign seed     = ctrl.word_open ? col_r : {{(lam_pkg::ROWS-1){1'b0}}, pos.first};

  // Deletion closure runs diagonally through the chain: (i-1,e-1) feeds (i,e).
  always_comb begin
    c1[0] = in_range & ctrl.row_mask[0] & seed[0];
    v[0]  = left.col1[0] & left.hit;
    c2[0] = in_range & ctrl.row_mask[0] & v[0];
    for (int e = 1; e < lam_pkg::ROWS; e++) begin
      c1[e] = in_range & ctrl.row_mask[e] &
              (seed[e] | (left.below & left.col1[e-1]));
      v[e]  = (left.col1[e] & left.hit) | c1[e-1] | (left.col1[e-1] & left.below);
      c2[e] = in_range & ctrl.row_mask[e] &
              (v[e] | (left.below & left.col2[e-1]));
    end
  end

  assign col_nxt = ctrl.is_symbol ? c2 : c1;
  assign tap     = pos.at & (|col_nxt);

  assign right.col1  = c1;
  assign right.col2  = c2;
  assign right.hit   = hit;
  assign right.below = pos.below;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (ctrl.step) begin
      col_r <= col_nxt;
    end
  end

endmodule

/* hdl/levenshtein_automaton_matcher_unit.sv */
// Levenshtein automaton matcher: tells whether a streamed word is within a set
// number of edits of a configured pattern of up to 16 bytes.
// Input stream: in_tdata carries one byte, in_tuser says whether that byte is
// consumed (0 for a bare item), in_tlast ends the word. Every request whose
// in_tlast is set returns one result request on the output stream;
// out_tdata[0] is 1 when the word is within distance.
// Config port: cfg_index 0/1 pattern bytes 0-7/8-15, 2 pattern length,
// 3 edit limit; other indexes are ignored. cfg_ready is always high. Write
// only while no word is in progress.
// Throughput: one input request per cycle unless stalled. A row of 17 cells,
// one per pattern position, updates all edit counts of the NFA in the cycle
// the byte is taken. The result is in the output register in the cycle after
// the word end is accepted. The input stalls only while that register is
// full and out_tready is low; in_tready follows out_tready while a result
// waits, so the next input request is taken in the same cycle the result drains.
// Reset (synchronous, rst_n low) clears the NFA state, ends any open word,
// empties the output register and restores the registers to length 0,
// edit limit 1.
`include "levenshtein_automaton_matcher_unit_macros.svh"

module levenshtein_automaton_matcher_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] symbol
  input  logic                             in_tuser,   // [0] is_symbol
  input  logic                             in_tlast,   // word_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [0] within_distance, rest 0
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lam_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lam_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [63:0]                    pattern_low_r;
  logic [63:0]                    pattern_high_r;
  logic [lam_pkg::LENGTH_W-1:0]   pattern_length_r;
  logic [lam_pkg::EDITS_W-1:0]    max_edits_r;

  logic                           word_open_r;
  logic                           word_open_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic                           out_data_r;
  logic                           out_data_nxt;

  logic                           in_acc;
  logic                           cfg_acc;
  logic [lam_pkg::LENGTH_W-1:0]   n_eff;
  logic [127:0]                   pattern;
  logic [lam_pkg::CELLS-1:0]      taps;
  lam_pkg::lam_ctrl_t             ctrl;
  lam_pkg::lam_link_t             links [lam_pkg::CELLS+1];

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= '0;
      max_edits_r      <= lam_pkg::EDITS_W'(1);
    end else if (cfg_acc) begin
      unique case (cfg_index)
        lam_pkg::REG_PATTERN_LOW:    pattern_low_r    <= cfg_data[63:0];
        lam_pkg::REG_PATTERN_HIGH:   pattern_high_r   <= cfg_data[63:0];
        lam_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[lam_pkg::LENGTH_W-1:0];
        lam_pkg::REG_MAX_EDITS:      max_edits_r      <= cfg_data[lam_pkg::EDITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (int'(pattern_length_r) > lam_pkg::PATTERN_MAX) ?
                 lam_pkg::LENGTH_W'(lam_pkg::PATTERN_MAX) : pattern_length_r;
  assign pattern = {pattern_high_r, pattern_low_r};

  // Rows above the edit limit are dropped; the clamp to EDITS_MAX falls out.
  always_comb begin
    ctrl.step      = in_acc;
    ctrl.word_open = word_open_r;
    ctrl.is_symbol = in_tuser;
    ctrl.symbol    = in_tdata;
    for (int e = 0; e < lam_pkg::ROWS; e++) begin
      ctrl.row_mask[e] = (e <= int'(max_edits_r));
    end
  end

  assign links[0] = '0;

  for (genvar i = 0; i < lam_pkg::CELLS; i++) begin : g_cell
    lam_pkg::lam_pos_t             pos;
    logic [lam_pkg::SYMBOL_W-1:0]  pat_byte;

    assign pos.first = (i == 0);
    assign pos.below = (lam_pkg::LENGTH_W'(i) < n_eff);
    assign pos.at    = (lam_pkg::LENGTH_W'(i) == n_eff);

    if (i < lam_pkg::PATTERN_MAX) begin : g_byte
      assign pat_byte = pattern[8*i +: 8];
    end else begin : g_nobyte
      assign pat_byte = '0;
    end

    lam_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .pos      (pos),
      .pat_byte (pat_byte),
      .left     (links[i]),
      .right    (links[i+1]),
      .tap      (taps[i])
    );
  end

  always_comb begin
    word_open_nxt = word_open_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      word_open_nxt = ~in_tlast;
      if (in_tlast) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = |taps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_open_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      word_open_r <= word_open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r};

  `LAM_ASSERT_NOW(a_result_from_word_end, $rose(out_tvalid), $past(in_acc && in_tlast), "result request without a word end")
  `LAM_ASSERT_NEXT(a_word_closes, in_acc && in_tlast, !word_open_r, "word still open after its end")
  `LAM_ASSERT_NEXT(a_mid_word_quiet, in_acc && !in_tlast, out_valid_r == $past(out_valid_r && !out_tready), "non-final request changed the output")

endmodule
